// ----- rtl/cdq_pkg.sv -----
// Package for the circular deque unit: transfer payload types, request and
// status codes, and the control word handed to every storage cell.
// No dependencies.
package cdq_pkg;

  localparam logic [1:0] ACT_PUSH_BACK  = 2'd0;
  localparam logic [1:0] ACT_PUSH_FRONT = 2'd1;
  localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
  localparam logic [1:0] ACT_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_MODE  = 2'd3;

  localparam logic MODE_IN_RESTRICTED  = 1'b0;
  localparam logic MODE_OUT_RESTRICTED = 1'b1;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] push_value;
  } cdq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic [3:0]         fill_count;
  } cdq_out_t;

  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_back;
    logic pop_back;
  } cdq_op_t;

endpackage

// ----- rtl/cdq_cell.sv -----
// One storage cell of the deque row: holds one entry and its occupied flag.
// Entries stay packed from cell 0 (front); front ops shift the whole row.
// Depends on cdq_pkg.
module cdq_cell
  import cdq_pkg::*;
#(
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cdq_op_t              op,
  input  logic [DATA_BITS-1:0] push_data,
  input  logic                 left_valid,
  input  logic [DATA_BITS-1:0] left_data,
  input  logic                 right_valid,
  input  logic [DATA_BITS-1:0] right_data,
  output logic                 valid,
  output logic [DATA_BITS-1:0] data,
  output logic                 tail
);

  logic                 valid_r;
  logic                 valid_nxt;
  logic [DATA_BITS-1:0] data_r;
  logic [DATA_BITS-1:0] data_nxt;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (op.push_front) begin
      valid_nxt = left_valid;
      data_nxt  = left_data;
    end else if (op.pop_front) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
    end else if (op.push_back) begin
      if (!valid_r && left_valid) begin
        valid_nxt = 1'b1;
        data_nxt  = push_data;
      end
    end else if (op.pop_back) begin
      if (valid_r && !right_valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;
  assign tail  = valid_r && !right_valid;

endmodule

// ----- rtl/circular_deque_unit.sv -----
// Top level of the circular deque unit: request decode, a row of cdq_cell
// storage cells, the mode register and the result register.
// Depends on cdq_pkg and cdq_cell.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in_     | input     | in_valid/in_stall  | cdq_in_t: action, push_value
//  out_    | output    | out_valid/out_stall| cdq_out_t: status, popped, count
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_data: restrict_mode
//
// One request per cycle while in_stall is low; its result appears in the result
// register in the cycle after the transfer. Each request is decoded and applied to
// every cell of the row in its transfer cycle; front ops shift the row by one cell.
// Reset (rst_n low, synchronous) empties the row and clears the mode.
// in_stall is high only while a result waits under out_stall.
// cfg_ready is always high.
module circular_deque_unit
  import cdq_pkg::*;
#(
  parameter int DEPTH     = 8,
  parameter int DATA_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  cdq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output cdq_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic                  mode_r;
  logic [CNT_BITS-1:0]   count_r;
  logic [CNT_BITS-1:0]   count_nxt;
  logic                  out_valid_r;
  cdq_out_t              out_data_r;
  cdq_out_t              result;

  logic                  in_xfer;
  logic                  mode_block;
  logic                  full;
  logic                  empty;
  logic [1:0]            status;
  cdq_op_t               op;
  logic signed [63:0]    push_ext;
  logic [DATA_BITS-1:0]  push_data;
  logic [DATA_BITS-1:0]  tail_data;
  logic signed [DATA_BITS-1:0] pop_data;
  logic signed [63:0]    pop_ext;

  logic                  cell_valid [DEPTH];
  logic [DATA_BITS-1:0]  cell_data  [DEPTH];
  logic                  cell_tail  [DEPTH];

  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign push_ext  = 64'(in_data.push_value);
  assign push_data = push_ext[DATA_BITS-1:0];
  assign full      = cell_valid[DEPTH-1];
  assign empty     = !cell_valid[0];

  always_comb begin
    mode_block = ((in_data.action == ACT_PUSH_FRONT) && (mode_r == MODE_IN_RESTRICTED)) ||
                 ((in_data.action == ACT_POP_BACK) && (mode_r == MODE_OUT_RESTRICTED));
    if (mode_block) begin
      status = ST_MODE;
    end else if ((in_data.action == ACT_PUSH_BACK) || (in_data.action == ACT_PUSH_FRONT)) begin
      status = full ? ST_FULL : ST_DONE;
    end else begin
      status = empty ? ST_EMPTY : ST_DONE;
    end
  end

  always_comb begin
    op        = '0;
    count_nxt = count_r;
    pop_data  = '0;
    if (in_xfer && (status == ST_DONE)) begin
      unique case (in_data.action)
        ACT_PUSH_BACK: begin
          op.push_back = 1'b1;
          count_nxt    = count_r + 1'b1;
        end
        ACT_PUSH_FRONT: begin
          op.push_front = 1'b1;
          count_nxt     = count_r + 1'b1;
        end
        ACT_POP_FRONT: begin
          op.pop_front = 1'b1;
          count_nxt    = count_r - 1'b1;
          pop_data     = cell_data[0];
        end
        ACT_POP_BACK: begin
          op.pop_back = 1'b1;
          count_nxt   = count_r - 1'b1;
          pop_data    = tail_data;
        end
        default: begin
          op = '0;
        end
      endcase
    end
  end

  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_data = tail_data | (cell_tail[i] ? cell_data[i] : '0);
    end
  end

  assign pop_ext = 64'(pop_data);

  always_comb begin
    result.status       = status;
    result.popped_value = pop_ext[31:0];
    result.fill_count   = 4'(count_nxt);
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                 lv;
    logic [DATA_BITS-1:0] ld;
    logic                 rv;
    logic [DATA_BITS-1:0] rd;

    if (g == 0) begin : g_first
      assign lv = 1'b1;
      assign ld = push_data;
    end else begin : g_mid_l
      assign lv = cell_valid[g-1];
      assign ld = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_mid_r
      assign rv = cell_valid[g+1];
      assign rd = cell_data[g+1];
    end

    cdq_cell #(
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .push_data   (push_data),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .valid       (cell_valid[g]),
      .data        (cell_data[g]),
      .tail        (cell_tail[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IN_RESTRICTED;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      count_r <= count_nxt;
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= in_xfer;
      end
    end
    if (in_xfer) begin
      out_data_r <= result;
    end
  end

`ifndef SYNTHESIS
  a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == !cell_valid[0])
    else $error("count and front cell occupancy disagree");

  a_full_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_BITS'(DEPTH)) == cell_valid[DEPTH-1])
    else $error("count and last cell occupancy disagree");

  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (status != ST_DONE)) |=> $stable(count_r))
    else $error("refused request changed the count");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (out_valid_r && (out_data_r.fill_count == 4'(count_r))))
    else $error("result register missed a transfer");
`endif

endmodule
